>>> rtl/kxk_image_convolution_unit_macros.svh
// Assertion macros used by the checker file of the convolution unit.
// Every macro samples on the rising edge of clock and is switched off
// while reset is high.
`ifndef KXK_IMAGE_CONVOLUTION_UNIT_MACROS_SVH
`define KXK_IMAGE_CONVOLUTION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KICU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KICU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/kicu_pkg.sv
`default_nettype none

package kicu_pkg;

   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 32;
   localparam int SUM_W     = 40;
   localparam int POS_W     = 8;   // signed window position, -3 .. 67
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
   localparam logic [1:0] OP_LOAD_PIXEL = 2'd1;
   localparam logic [1:0] OP_COMPUTE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [ROW_W-1:0]        out_row;
      logic [COL_W-1:0]        out_col;
      logic                    error;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

   typedef struct packed {
      logic pending;
   } mac_stat_type;

endpackage

`default_nettype wire

>>> rtl/kxk_image_convolution_unit.sv
`default_nettype none

// Channel       Ports                         Handshake
// item in       start, busy, req_data         taken when start is high and busy is low
// result out    rsp_valid, rsp_data           shown for one cycle, cannot be held off
// registers     csr_we, csr_index, csr_wdata  written on every edge with csr_we high
//
// Load items (coefficient or pixel) leave busy low.
// A query inside the image runs each tap of a KxK kernel through the single
// multiply-accumulate unit, then waits for the read and product registers to drain.
// A query outside the image gives its result on the next cycle.
// Reset is synchronous; the frame and coefficient memories are not cleared.
// The result receiver cannot stall, so the result is never held.
module kxk_image_convolution_unit #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_KERNEL = 7
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire kicu_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output kicu_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [kicu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kicu_pkg::CSR_W-1:0]          csr_wdata
);

   import kicu_pkg::*;

   localparam int PIX_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int PAW        = $clog2(PIX_DEPTH);
   localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int CAW        = $clog2(COEF_DEPTH);
   localparam int KW         = $clog2(MAX_KERNEL + 1);
   localparam int KSW        = (KW > 3) ? KW : 3;
   localparam int KTOP       = ((MAX_KERNEL % 2) == 0) ? MAX_KERNEL - 1 : MAX_KERNEL;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Configuration registers.
   logic [CSR_W-1:0] rows_cfg_ff;
   logic [CSR_W-1:0] cols_cfg_ff;
   logic [2:0]       ksize_cfg_ff;

   // Sequencer state and registered outputs.
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   r_ff, r_in;
   logic [POS_W-1:0]   c_ff, c_in;
   logic [KSW-1:0]     x_ff, x_in;
   logic [KSW-1:0]     y_ff, y_in;
   logic [CAW-1:0]     ca_ff, ca_in;

   // Effective kernel size: forced odd, at least 3, at most the largest
   // odd size that fits the coefficient store.
   logic [KSW-1:0] ks_odd;
   logic [KSW-1:0] ks_eff;
   logic [KSW-1:0] half;

   logic           accept;
   logic           query_err;
   logic           r_inside, c_inside;
   logic [6:0]     r_sel, c_sel;
   logic           last_tap;

   logic           coef_we, pix_we;
   logic [CAW-1:0] coef_waddr;
   logic [PAW-1:0] pix_waddr, pix_raddr;
   logic [VAL_W-1:0] coef_rdata, pix_rdata;

   mac_ctrl_type            mac_ctrl;
   mac_stat_type            mac_stat;
   logic signed [SUM_W-1:0] mac_acc;

   always_comb begin
      ks_odd = KSW'(ksize_cfg_ff) | KSW'(1);
      if (int'(ks_odd) < 3) begin
         ks_eff = KSW'(3);
      end else if (int'(ks_odd) > KTOP) begin
         ks_eff = KSW'(KTOP);
      end else begin
         ks_eff = ks_odd;
      end
      half = ks_eff >> 1;
   end

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // A query is in error when its position is not below the image size,
   // where the size is capped at the frame memory's dimensions.
   assign query_err = !(({1'b0, req_data.row} < rows_cfg_ff) && (int'(req_data.row) < MAX_ROWS)
                        && ({1'b0, req_data.col} < cols_cfg_ff)
                        && (int'(req_data.col) < MAX_COLS));

   // Loads write the stores directly; out-of-range loads are dropped.
   assign coef_we    = accept && (req_data.op == OP_LOAD_COEF)
                       && (int'(req_data.row) < MAX_KERNEL) && (int'(req_data.col) < MAX_KERNEL);
   assign pix_we     = accept && (req_data.op == OP_LOAD_PIXEL)
                       && (int'(req_data.row) < MAX_ROWS) && (int'(req_data.col) < MAX_COLS);
   assign coef_waddr = CAW'(int'(req_data.row) * MAX_KERNEL + int'(req_data.col));
   assign pix_waddr  = PAW'(int'(req_data.row) * MAX_COLS + int'(req_data.col));

   // A neighbor outside the image is read from the center address, which
   // yields the center pixel without a separate read.
   assign r_inside = !r_ff[POS_W-1] && (r_ff[6:0] < rows_cfg_ff) && (int'(r_ff[6:0]) < MAX_ROWS);
   assign c_inside = !c_ff[POS_W-1] && (c_ff[6:0] < cols_cfg_ff) && (int'(c_ff[6:0]) < MAX_COLS);

   always_comb begin
      if (r_inside && c_inside) begin
         r_sel = r_ff[6:0];
         c_sel = c_ff[6:0];
      end else begin
         r_sel = {1'b0, row_ff};
         c_sel = {1'b0, col_ff};
      end
   end

   assign pix_raddr = PAW'(int'(r_sel) * MAX_COLS + int'(c_sel));
   assign last_tap  = (x_ff == ks_eff - KSW'(1)) && (y_ff == ks_eff - KSW'(1));

   // Sequencer: one tap issued per cycle in ST_RUN, then the read and
   // product registers drain before the sum is shown.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_vld_in    = 1'b0;
      row_in       = row_ff;
      col_in       = col_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ca_in        = ca_ff;
      mac_ctrl     = '{clear: 1'b0, valid: rd_vld_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.op == OP_COMPUTE)) begin
               row_in         = req_data.row;
               col_in         = req_data.col;
               r_in           = POS_W'({2'b00, req_data.row}) - POS_W'(half);
               c_in           = POS_W'({2'b00, req_data.col}) - POS_W'(half);
               x_in           = '0;
               y_in           = '0;
               ca_in          = '0;
               mac_ctrl.clear = 1'b1;
               if (query_err) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{sum: '0, out_row: req_data.row,
                                   out_col: req_data.col, error: 1'b1};
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rd_vld_in = 1'b1;
            if (y_ff == ks_eff - KSW'(1)) begin
               y_in  = '0;
               x_in  = x_ff + KSW'(1);
               r_in  = r_ff + POS_W'(1);
               c_in  = POS_W'({2'b00, col_ff}) - POS_W'(half);
               ca_in = CAW'(int'(ca_ff) + MAX_KERNEL - int'(ks_eff) + 1);
            end else begin
               y_in  = y_ff + KSW'(1);
               c_in  = c_ff + POS_W'(1);
               ca_in = ca_ff + CAW'(1);
            end
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_stat.pending) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{sum: mac_acc, out_row: row_ff,
                                out_col: col_ff, error: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rows_cfg_ff  <= CSR_W'(64);
         cols_cfg_ff  <= CSR_W'(64);
         ksize_cfg_ff <= 3'd3;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS:   rows_cfg_ff  <= csr_wdata;
               CSR_COLS:   cols_cfg_ff  <= csr_wdata;
               CSR_KERNEL: ksize_cfg_ff <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ca_ff       <= ca_in;
   end

   kicu_ram #(
      .WIDTH (VAL_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_data.value),
      .rd_addr (ca_ff),
      .rd_data (coef_rdata)
   );

   kicu_ram #(
      .WIDTH (VAL_W),
      .DEPTH (PIX_DEPTH)
   ) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (pix_waddr),
      .wr_data (req_data.value),
      .rd_addr (pix_raddr),
      .rd_data (pix_rdata)
   );

   kicu_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  ($signed(coef_rdata)),
      .pixel ($signed(pix_rdata)),
      .stat  (mac_stat),
      .acc   (mac_acc)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/kicu_ram.sv
`default_nettype none

module kicu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/kicu_mac.sv
`default_nettype none

// Shared multiply-accumulate unit: one product per cycle, registered before
// it is added into the accumulator.
module kicu_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire kicu_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [kicu_pkg::VAL_W-1:0]    coef,
   input  wire logic signed [kicu_pkg::VAL_W-1:0]    pixel,
   output kicu_pkg::mac_stat_type                    stat,
   output logic signed [kicu_pkg::SUM_W-1:0]         acc
);

   import kicu_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = PROD_W'(coef) * PROD_W'(pixel);
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.valid;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign stat.pending = prod_vld_ff;
   assign acc          = acc_ff;

endmodule

`default_nettype wire

>>> rtl/kicu_checker.sv
`default_nettype none

`include "kxk_image_convolution_unit_macros.svh"

module kicu_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire kicu_pkg::req_type                req_data,
   input wire logic                             rsp_valid,
   input wire kicu_pkg::rsp_type                rsp_data,
   input wire logic                             csr_we,
   input wire logic [kicu_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [kicu_pkg::CSR_W-1:0]       csr_wdata
);

   import kicu_pkg::*;

   logic load_taken;
   logic query_taken;
   logic unused_csr;

   assign load_taken  = start && !busy && (req_data.op != OP_COMPUTE);
   assign query_taken = start && !busy && (req_data.op == OP_COMPUTE);
   assign unused_csr  = csr_we ^ (|csr_index) ^ (|csr_wdata);

   // A load finishes at once and never produces a result.
   `KICU_ASSERT_NEXT(a_load_quiet, load_taken, !busy && !rsp_valid, "load item left a trace")
   // A query either answers at once (error) or keeps the block busy.
   `KICU_ASSERT_NEXT(a_query_acts, query_taken, busy || rsp_valid, "query item was dropped")
   // Results are shown only while the block is idle.
   `KICU_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result shown while busy")
   // Finishing a query always shows its result.
   `KICU_ASSERT_SAME(a_done_rsp, $fell(busy), rsp_valid, "query ended without a result")
   // An error result carries a zero sum.
   `KICU_ASSERT_SAME(a_err_zero, rsp_valid && rsp_data.error, rsp_data.sum == '0,
                     "error result with nonzero sum")

endmodule

bind kxk_image_convolution_unit kicu_checker u_kicu_checker (.*);

`default_nettype wire
